### rtl/fhi_pkg.sv
// Package for the fixed-Huffman inflate unit: codes, length and distance tables, control structs.
package fhi_pkg;

    // Default parameter values.
    localparam int DEF_STORED_BLOCK_LEN = 65536;
    localparam int DEF_HISTORY_DEPTH    = 32768;
    localparam int DEF_BYTES_PER_RESULT = 8;
    localparam int OUT_BYTES            = 8;

    // Decode phases.
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_STORED = 3'd1;
    localparam logic [2:0] PH_SYM    = 3'd2;
    localparam logic [2:0] PH_SYMX   = 3'd3;
    localparam logic [2:0] PH_LENX   = 3'd4;
    localparam logic [2:0] PH_DIST   = 3'd5;
    localparam logic [2:0] PH_DISTX  = 3'd6;

    // Error codes.
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_LEN   = 2'd1;
    localparam logic [1:0] ERR_DIST  = 2'd2;
    localparam logic [1:0] ERR_TRUNC = 2'd3;

    // Static length and distance tables.
    localparam logic [8:0] LEN_BASE [0:28] = '{
        9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15, 9'd17,
        9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67, 9'd83, 9'd99,
        9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258};
    localparam logic [2:0] LEN_EXTRA [0:28] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd0};
    localparam logic [15:0] DIST_BASE [0:29] = '{
        16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd9, 16'd13, 16'd17, 16'd25,
        16'd33, 16'd49, 16'd65, 16'd97, 16'd129, 16'd193, 16'd257, 16'd385, 16'd513,
        16'd769, 16'd1025, 16'd1537, 16'd2049, 16'd3073, 16'd4097, 16'd6145,
        16'd8193, 16'd12289, 16'd16385, 16'd24577};
    localparam logic [3:0] DIST_EXTRA [0:29] = '{
        4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
        4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10,
        4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13};

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load;
        logic header;
        logic stored;
        logic bit_step;
        logic reduce;
        logic rd;
        logic copy_wr;
        logic push;
        logic push_last;
    } fhi_cmd_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic done;
        logic phase_hdr;
        logic phase_stored;
        logic bits_left;
        logic copy_req;
        logic pend_full;
        logic out_free;
        logic dist_ok;
        logic len_zero;
    } fhi_status_t;

endpackage

### rtl/fhi_datapath.sv
// Datapath of the inflate unit: bit decoder, copy registers, history memory and output word.
module fhi_datapath
    import fhi_pkg::*;
#(
    parameter int STORED_BLOCK_LEN = DEF_STORED_BLOCK_LEN,
    parameter int HISTORY_DEPTH    = DEF_HISTORY_DEPTH,
    parameter int BYTES_PER_RESULT = DEF_BYTES_PER_RESULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fhi_cmd_t          cmd,
    output fhi_status_t       st,
    input  logic [7:0]        in_byte,
    input  logic              in_final,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [7:0]        out_bytes [OUT_BYTES],
    output logic [3:0]        out_count,
    output logic              out_last,
    output logic              stream_done,
    output logic [1:0]        error_code
);

    localparam int HW = $clog2(HISTORY_DEPTH);
    localparam int RW = $clog2(STORED_BLOCK_LEN + 1);
    localparam int PW = (BYTES_PER_RESULT > 1) ? $clog2(BYTES_PER_RESULT) : 1;

    // Control and decode state.
    logic [7:0]  byte_reg;
    logic        fin_reg;
    logic [3:0]  bit_cnt_reg,  bit_cnt_next;
    logic [2:0]  phase_reg,    phase_next;
    logic [12:0] accum_reg,    accum_next;
    logic [3:0]  acc_bits_reg, acc_bits_next;
    logic [3:0]  need_reg,     need_next;
    logic [8:0]  len_reg,      len_next;
    logic [15:0] dist_reg,     dist_next;
    logic [RW-1:0] rem_reg,    rem_next;
    logic        last_blk_reg, last_blk_next;
    logic        done_reg,     done_next;
    logic [1:0]  err_reg,      err_next;
    logic [HW-1:0] hp_reg,     hp_next;
    logic [HW-1:0] pos_reg,    pos_next;
    logic [3:0]  pend_n_reg,   pend_n_next;
    logic        out_valid_reg;

    // Payload.
    logic [7:0] pend_reg [BYTES_PER_RESULT];
    logic       pend_done_reg;
    logic [7:0] pend8 [OUT_BYTES];
    logic [7:0] hist_mem [HISTORY_DEPTH];
    logic [7:0] rd_data_reg;
    logic [7:0] out_bytes_reg [OUT_BYTES];
    logic [3:0] out_count_reg;
    logic       out_last_reg;
    logic       out_done_reg;
    logic [1:0] out_err_reg;

    // Bit decoder signals.
    logic [12:0] c_new;
    logic [3:0]  bits_new;
    logic [8:0]  sym;
    logic [4:0]  len_idx;
    logic [2:0]  e_sym;
    logic        copy_req_c;
    logic        emit_en;
    logic [7:0]  emit_byte;
    logic        fin_fail;
    logic [16:0] hp17, d17, pos17;

    function automatic logic [HW-1:0] ptr_inc(input logic [HW-1:0] p);
        ptr_inc = (p == HW'(HISTORY_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign c_new    = {accum_reg[11:0], byte_reg[7]};
    assign bits_new = acc_bits_reg + 4'd1;
    assign len_idx  = 5'(sym - 9'd257);
    assign fin_fail = fin_reg && !done_reg;
    assign hp17     = 17'(hp_reg);
    assign d17      = {1'b0, dist_reg};
    assign pos17    = (d17 > hp17) ? (hp17 + 17'(HISTORY_DEPTH) - d17) : (hp17 - d17);

    // Symbol value for a completed literal/length code.
    always_comb
    begin
        if (need_reg == 4'd7)
        begin
            sym = 9'({2'b00, c_new[6:0]} + 9'd256);
        end
        else if (need_reg == 4'd8)
        begin
            sym = (c_new[7:0] < 8'hC0) ? {1'b0, 8'(c_new[7:0] - 8'd48)}
                                       : 9'({1'b0, c_new[7:0]} + 9'd88);
        end
        else
        begin
            sym = {1'b0, c_new[7:0]};
        end
    end

    // Extra code bits implied by the first five bits of a symbol.
    always_comb
    begin
        unique case (c_new[4:3])
            2'd1, 2'd2: e_sym = 3'd3;
            2'd0:       e_sym = (c_new[2:1] == 2'd3) ? 3'd3 : 3'd2;
            default:    e_sym = (c_new[2:0] == 3'd0) ? 3'd3 : 3'd4;
        endcase
    end

    // Next-state logic for all decode state.
    always_comb
    begin
        bit_cnt_next  = bit_cnt_reg;
        phase_next    = phase_reg;
        accum_next    = accum_reg;
        acc_bits_next = acc_bits_reg;
        need_next     = need_reg;
        len_next      = len_reg;
        dist_next     = dist_reg;
        rem_next      = rem_reg;
        last_blk_next = last_blk_reg;
        done_next     = done_reg;
        err_next      = err_reg;
        hp_next       = hp_reg;
        pos_next      = pos_reg;
        pend_n_next   = pend_n_reg;
        copy_req_c    = 1'b0;
        emit_en       = 1'b0;
        emit_byte     = byte_reg;

        if (cmd.load)
        begin
            bit_cnt_next = 4'd8;
        end

        // Block header byte.
        if (cmd.header)
        begin
            last_blk_next = byte_reg[7];
            if (byte_reg[5])
            begin
                phase_next    = PH_SYM;
                accum_next    = '0;
                acc_bits_next = '0;
                need_next     = 4'd5;
            end
            else
            begin
                phase_next = PH_STORED;
                rem_next   = RW'(STORED_BLOCK_LEN);
                if (fin_reg)
                begin
                    done_next  = byte_reg[7];
                    phase_next = PH_HEADER;
                end
            end
        end

        // Stored block byte.
        if (cmd.stored)
        begin
            if (rem_reg == '0 || (fin_reg && rem_reg > RW'(1)))
            begin
                done_next  = done_reg | last_blk_reg;
                phase_next = PH_HEADER;
            end
            else
            begin
                emit_en  = 1'b1;
                rem_next = rem_reg - 1'b1;
                if (fin_reg)
                begin
                    done_next  = done_reg | last_blk_reg;
                    phase_next = PH_HEADER;
                end
            end
        end

        // One compressed bit.
        if (cmd.bit_step)
        begin
            bit_cnt_next = bit_cnt_reg - 4'd1;
            if (bits_new < need_reg)
            begin
                accum_next    = c_new;
                acc_bits_next = bits_new;
            end
            else
            begin
                accum_next    = '0;
                acc_bits_next = '0;
                unique case (phase_reg)
                    PH_SYM:
                    begin
                        phase_next    = PH_SYMX;
                        need_next     = 4'd5 + {1'b0, e_sym};
                        accum_next    = c_new;
                        acc_bits_next = bits_new;
                    end
                    PH_SYMX:
                    begin
                        if (sym < 9'd256)
                        begin
                            emit_en    = 1'b1;
                            emit_byte  = sym[7:0];
                            phase_next = PH_SYM;
                            need_next  = 4'd5;
                        end
                        else if (sym == 9'd256)
                        begin
                            done_next  = done_reg | last_blk_reg;
                            phase_next = PH_HEADER;
                        end
                        else if (sym > 9'd285)
                        begin
                            err_next  = ERR_LEN;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            len_next = LEN_BASE[len_idx];
                            if (LEN_EXTRA[len_idx] != 3'd0)
                            begin
                                phase_next = PH_LENX;
                                need_next  = {1'b0, LEN_EXTRA[len_idx]};
                            end
                            else
                            begin
                                phase_next = PH_DIST;
                                need_next  = 4'd5;
                            end
                        end
                    end
                    PH_LENX:
                    begin
                        len_next   = 9'(len_reg + {4'd0, c_new[4:0]});
                        phase_next = PH_DIST;
                        need_next  = 4'd5;
                    end
                    PH_DIST:
                    begin
                        if (c_new[4:0] >= 5'd30)
                        begin
                            err_next  = ERR_DIST;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            dist_next = DIST_BASE[c_new[4:0]];
                            if (DIST_EXTRA[c_new[4:0]] != 4'd0)
                            begin
                                phase_next = PH_DISTX;
                                need_next  = DIST_EXTRA[c_new[4:0]];
                            end
                            else
                            begin
                                copy_req_c = 1'b1;
                                phase_next = PH_SYM;
                                need_next  = 4'd5;
                            end
                        end
                    end
                    default:
                    begin
                        dist_next  = 16'(dist_reg + {3'd0, c_new});
                        copy_req_c = 1'b1;
                        phase_next = PH_SYM;
                        need_next  = 4'd5;
                    end
                endcase
            end
        end

        // Distance reduction and copy start address.
        if (cmd.reduce)
        begin
            if (st.dist_ok)
            begin
                pos_next = pos17[HW-1:0];
            end
            else
            begin
                dist_next = 16'(d17 - 17'(HISTORY_DEPTH));
            end
        end

        // One copied byte.
        if (cmd.copy_wr)
        begin
            emit_en   = 1'b1;
            emit_byte = rd_data_reg;
            pos_next  = ptr_inc(pos_reg);
            len_next  = len_reg - 9'd1;
        end

        if (emit_en)
        begin
            hp_next     = ptr_inc(hp_reg);
            pend_n_next = pend_n_reg + 4'd1;
        end

        if (cmd.push || cmd.push_last)
        begin
            pend_n_next = '0;
        end

        if (cmd.push_last && fin_fail)
        begin
            done_next = 1'b1;
            err_next  = ERR_TRUNC;
        end
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg   <= '0;
            phase_reg     <= PH_HEADER;
            accum_reg     <= '0;
            acc_bits_reg  <= '0;
            need_reg      <= '0;
            len_reg       <= '0;
            dist_reg      <= '0;
            rem_reg       <= '0;
            last_blk_reg  <= 1'b0;
            done_reg      <= 1'b0;
            err_reg       <= ERR_NONE;
            hp_reg        <= '0;
            pos_reg       <= '0;
            pend_n_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bit_cnt_reg   <= bit_cnt_next;
            phase_reg     <= phase_next;
            accum_reg     <= accum_next;
            acc_bits_reg  <= acc_bits_next;
            need_reg      <= need_next;
            len_reg       <= len_next;
            dist_reg      <= dist_next;
            rem_reg       <= rem_next;
            last_blk_reg  <= last_blk_next;
            done_reg      <= done_next;
            err_reg       <= err_next;
            hp_reg        <= hp_next;
            pos_reg       <= pos_next;
            pend_n_reg    <= pend_n_next;
            if (cmd.push || cmd.push_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Input byte and shift register.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg <= in_byte;
            fin_reg  <= in_final;
        end
        else if (cmd.bit_step)
        begin
            byte_reg <= {byte_reg[6:0], 1'b0};
        end
    end

    // History ring: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (emit_en)
        begin
            hist_mem[hp_reg] <= emit_byte;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= hist_mem[pos_reg];
        end
    end

    // Pending bytes of the word being assembled, with the stream status as each byte was made.
    always_ff @(posedge clk)
    begin
        if (emit_en)
        begin
            pend_reg[pend_n_reg[PW-1:0]] <= emit_byte;
            pend_done_reg                <= done_reg;
        end
    end

    for (genvar j = 0; j < OUT_BYTES; j++)
    begin : g_pend
        if (j < BYTES_PER_RESULT)
        begin : g_used
            assign pend8[j] = pend_reg[j];
        end
        else
        begin : g_unused
            assign pend8[j] = 8'd0;
        end
    end

    // Output word register. A full word carries the status from when its last byte was made.
    always_ff @(posedge clk)
    begin
        if (cmd.push || cmd.push_last)
        begin
            for (int j = 0; j < OUT_BYTES; j++)
            begin
                out_bytes_reg[j] <= (4'(j) < pend_n_reg) ? pend8[j] : 8'd0;
            end
            out_count_reg <= pend_n_reg;
            out_last_reg  <= cmd.push_last;
            out_done_reg  <= cmd.push_last ? (done_reg | fin_fail) : pend_done_reg;
            out_err_reg   <= (cmd.push_last && fin_fail) ? ERR_TRUNC : err_reg;
        end
    end

    // Status to the sequencer.
    always_comb
    begin
        st.done         = done_reg;
        st.phase_hdr    = (phase_reg == PH_HEADER);
        st.phase_stored = (phase_reg == PH_STORED);
        st.bits_left    = (bit_cnt_reg != 4'd0);
        st.copy_req     = copy_req_c;
        st.pend_full    = (pend_n_reg == 4'(BYTES_PER_RESULT));
        st.out_free     = !out_valid_reg || out_ready;
        st.dist_ok      = (d17 < 17'(HISTORY_DEPTH));
        st.len_zero     = (len_reg == 9'd0);
    end

    assign out_valid   = out_valid_reg;
    assign out_bytes   = out_bytes_reg;
    assign out_count   = out_count_reg;
    assign out_last    = out_last_reg;
    assign stream_done = out_done_reg;
    assign error_code  = out_err_reg;

endmodule

### rtl/fhi_ctrl.sv
// Sequencer of the inflate unit: steps bits, copies and word pushes for each input byte.
module fhi_ctrl
    import fhi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  fhi_status_t st,
    output fhi_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_BYTE   = 3'd1;
    localparam logic [2:0] ST_BITS   = 3'd2;
    localparam logic [2:0] ST_REDUCE = 3'd3;
    localparam logic [2:0] ST_CRD    = 3'd4;
    localparam logic [2:0] ST_CWR    = 3'd5;
    localparam logic [2:0] ST_FINAL  = 3'd6;

    logic [2:0] state_reg, state_next;

    // Next state and commands.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_BYTE;
                end
            end
            ST_BYTE:
            begin
                if (st.done)
                begin
                    state_next = ST_FINAL;
                end
                else if (st.phase_hdr)
                begin
                    cmd.header = 1'b1;
                    state_next = ST_FINAL;
                end
                else if (st.phase_stored)
                begin
                    cmd.stored = 1'b1;
                    state_next = ST_FINAL;
                end
                else
                begin
                    state_next = ST_BITS;
                end
            end
            ST_BITS:
            begin
                if (st.pend_full)
                begin
                    cmd.push = st.out_free;
                end
                else if (st.done || st.phase_hdr || !st.bits_left)
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    cmd.bit_step = 1'b1;
                    if (st.copy_req)
                    begin
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                cmd.reduce = 1'b1;
                if (st.dist_ok)
                begin
                    state_next = ST_CRD;
                end
            end
            ST_CRD:
            begin
                if (st.pend_full)
                begin
                    cmd.push = st.out_free;
                end
                else if (st.len_zero)
                begin
                    state_next = ST_BITS;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_CWR;
                end
            end
            ST_CWR:
            begin
                cmd.copy_wr = 1'b1;
                state_next  = ST_CRD;
            end
            ST_FINAL:
            begin
                if (st.pend_full)
                begin
                    cmd.push = st.out_free;
                end
                else if (st.out_free)
                begin
                    cmd.push_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A word is only pushed into a free output register.
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push || cmd.push_last) |-> st.out_free)
        else $error("word pushed while output register busy");

    // No byte is produced while the pending word is full.
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.stored || cmd.bit_step || cmd.copy_wr) |-> !st.pend_full)
        else $error("byte produced into a full pending word");

    // The closing word of a byte returns the unit to taking input.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_last |=> in_ready)
        else $error("unit not ready after closing word");

    // A history read is always followed by its write-back.
    a_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |=> cmd.copy_wr)
        else $error("history read without copy write");
`endif

endmodule

### rtl/fixed_huffman_inflate_unit.sv
// Top level of the fixed-Huffman and stored-block inflate unit.
//
// Takes one compressed byte per input word and returns one or more output words of up to
// BYTES_PER_RESULT decoded bytes, the last word of each input byte marked by out_last. A header
// byte or a stored data byte passes through acceptance, the decode step and the closing word. A
// byte of a fixed-Huffman block is accepted, then the decoder takes one bit a cycle unless a full
// word waits on the output and, once it finds the byte used up, makes the closing word. A copy
// first forms the start address, subtracting HISTORY_DEPTH from the distance in steps while it
// is not below HISTORY_DEPTH, then reads and then writes each copied byte in turn and finds
// the copy complete. Each output word before the closing one is pushed in a step of its own,
// and a stalled output holds the decoder.
module fixed_huffman_inflate_unit
    import fhi_pkg::*;
#(
    parameter int STORED_BLOCK_LEN = DEF_STORED_BLOCK_LEN,
    parameter int HISTORY_DEPTH    = DEF_HISTORY_DEPTH,
    parameter int BYTES_PER_RESULT = DEF_BYTES_PER_RESULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_final,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte0,
    output logic [7:0] out_byte1,
    output logic [7:0] out_byte2,
    output logic [7:0] out_byte3,
    output logic [7:0] out_byte4,
    output logic [7:0] out_byte5,
    output logic [7:0] out_byte6,
    output logic [7:0] out_byte7,
    output logic [3:0] out_count,
    output logic       out_last,
    output logic       stream_done,
    output logic [1:0] error_code
);

    fhi_cmd_t    cmd;
    fhi_status_t st;
    logic [7:0]  bytes [OUT_BYTES];

    // Sequencer.
    fhi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // Decoder datapath and history.
    fhi_datapath #(
        .STORED_BLOCK_LEN (STORED_BLOCK_LEN),
        .HISTORY_DEPTH    (HISTORY_DEPTH),
        .BYTES_PER_RESULT (BYTES_PER_RESULT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .in_byte     (in_byte),
        .in_final    (in_final),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .out_bytes   (bytes),
        .out_count   (out_count),
        .out_last    (out_last),
        .stream_done (stream_done),
        .error_code  (error_code)
    );

    assign out_byte0 = bytes[0];
    assign out_byte1 = bytes[1];
    assign out_byte2 = bytes[2];
    assign out_byte3 = bytes[3];
    assign out_byte4 = bytes[4];
    assign out_byte5 = bytes[5];
    assign out_byte6 = bytes[6];
    assign out_byte7 = bytes[7];

endmodule

### verif/fixed_huffman_inflate_unit_tb.sv
// Testbench for the fixed-Huffman inflate unit: stream builder, decode predictor and checker.
`timescale 1ns / 1ps

module fixed_huffman_inflate_unit_tb;
    import fhi_pkg::*;

    localparam int HIST_SIZE  = 32768;
    localparam int IDLE_LIMIT = 20000;

    // Stream end scenarios, one chosen per run.
    typedef enum int {
        END_BAD_LEN,
        END_BAD_DIST,
        END_CUT_FIXED,
        END_LAST_FIXED,
        END_LAST_STORED,
        END_STORED_HDR_FINAL,
        END_STORED_OPEN
    } stream_end_t;

    // Kinds of row in the directed symbol table.
    typedef enum int {ROW_LIT, ROW_COPY, ROW_EOB} row_kind_t;

    typedef struct {
        row_kind_t kind;
        int        arg_a;
        int        arg_b;
    } sym_row_t;

    typedef struct {
        logic [7:0] data;
        logic       fin;
    } in_word_t;

    typedef struct {
        logic [7:0] bytes [OUT_BYTES];
        logic [3:0] count;
        logic       last;
        logic       done;
        logic [1:0] err;
    } out_word_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       in_final;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte0, out_byte1, out_byte2, out_byte3;
    logic [7:0] out_byte4, out_byte5, out_byte6, out_byte7;
    logic [3:0] out_count;
    logic       out_last;
    logic       stream_done;
    logic [1:0] error_code;

    fixed_huffman_inflate_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .in_final   (in_final),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte0  (out_byte0),
        .out_byte1  (out_byte1),
        .out_byte2  (out_byte2),
        .out_byte3  (out_byte3),
        .out_byte4  (out_byte4),
        .out_byte5  (out_byte5),
        .out_byte6  (out_byte6),
        .out_byte7  (out_byte7),
        .out_count  (out_count),
        .out_last   (out_last),
        .stream_done(stream_done),
        .error_code (error_code)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    in_word_t  comp_stream [$];
    out_word_t decoded_due [$];
    int        fail_count;
    int        words_checked;
    int        bytes_sent;
    int        idle_cycles;
    bit        lazy_side;

    // Stream builder state: bit packer and count of bytes decoded so far.
    logic [7:0] pack_byte;
    int         pack_bits;
    int         built_len;

    // Decoder state of the predictor.
    logic [7:0]  hist [HIST_SIZE];
    logic [14:0] hist_ptr;
    logic [2:0]  phase;
    logic [15:0] accum;
    int          acc_have;
    int          acc_need;
    logic [8:0]  run_len;
    logic [15:0] run_dist;
    int          stored_left;
    logic        last_blk;
    logic        done_flag;
    logic [1:0]  err_state;
    logic [7:0]  pend [OUT_BYTES];
    int          pend_n;

    // Bit packing, most significant bit first.
    task automatic pack_bits_msb(input int value, input int nbits);
        int i;
        for (i = nbits - 1; i >= 0; i--)
        begin
            pack_byte = {pack_byte[6:0], 1'(value >> i)};
            pack_bits++;
            if (pack_bits == 8)
            begin
                comp_stream.push_back('{pack_byte, 1'b0});
                pack_bits = 0;
            end
        end
    endtask

    // Pads the open byte with random bits.
    task automatic pad_byte();
        if (pack_bits > 0)
            pack_bits_msb($urandom, 8 - pack_bits);
    endtask

    task automatic build_literal(input int lit);
        if (lit < 144)
            pack_bits_msb(lit + 'h30, 8);
        else
            pack_bits_msb(lit - 144 + 'h190, 9);
        built_len++;
    endtask

    // Writes a length/distance pair with its extra bits.
    task automatic build_copy(input int len, input int back_dist);
        int li;
        int di;
        int sym;
        li = 28;
        while (LEN_BASE[li] > len)
            li--;
        if (len == 258)
            li = 28;
        sym = 257 + li;
        if (sym < 280)
            pack_bits_msb(sym - 256, 7);
        else
            pack_bits_msb(sym - 280 + 'hC0, 8);
        pack_bits_msb(len - LEN_BASE[li], LEN_EXTRA[li]);
        di = 29;
        while (DIST_BASE[di] > back_dist)
            di--;
        pack_bits_msb(di, 5);
        pack_bits_msb(back_dist - DIST_BASE[di], DIST_EXTRA[di]);
        built_len += len;
    endtask

    // End of block code, then the rest of the byte is thrown away.
    task automatic build_eob();
        pack_bits_msb(0, 7);
        pad_byte();
    endtask

    task automatic build_header(input bit last, input bit fixed);
        logic [7:0] h;
        h = 8'($urandom);
        h[7] = last;
        h[5] = fixed;
        comp_stream.push_back('{h, 1'b0});
    endtask

    task automatic build_random_copy();
        int lim;
        int back_dist;
        lim = (built_len > HIST_SIZE) ? HIST_SIZE : built_len;
        if ($urandom_range(0, 3) == 0)
            back_dist = $urandom_range(1, lim);
        else
            back_dist = $urandom_range(1, (lim < 64) ? lim : 64);
        if ($urandom_range(0, 9) == 0)
            build_copy($urandom_range(200, 258), back_dist);
        else
            build_copy($urandom_range(3, 40), back_dist);
    endtask

    // Result word assembly for the predictor.
    task automatic close_word(input logic last);
        out_word_t w;
        int j;
        for (j = 0; j < OUT_BYTES; j++)
            w.bytes[j] = (j < pend_n) ? pend[j] : 8'h00;
        w.count = 4'(pend_n);
        w.last  = last;
        w.done  = done_flag;
        w.err   = err_state;
        decoded_due.push_back(w);
        pend_n = 0;
    endtask

    task automatic emit_byte(input logic [7:0] b);
        hist[hist_ptr] = b;
        hist_ptr++;
        pend[pend_n] = b;
        pend_n++;
        if (pend_n == OUT_BYTES)
            close_word(1'b0);
    endtask

    task automatic finish_block();
        if (last_blk)
            done_flag = 1'b1;
        phase = PH_HEADER;
    endtask

    task automatic abort_stream(input logic [1:0] code);
        err_state = code;
        done_flag = 1'b1;
    endtask

    task automatic open_field(input logic [2:0] ph, input int need);
        phase    = ph;
        accum    = '0;
        acc_have = 0;
        acc_need = need;
    endtask

    task automatic copy_back();
        logic [14:0] pos;
        int i;
        pos = hist_ptr - run_dist[14:0];
        for (i = 0; i < run_len; i++)
        begin
            emit_byte(hist[pos]);
            pos++;
        end
    endtask

    // One code bit through the symbol, length and distance decoder.
    task automatic decode_bit(input logic b);
        logic [15:0] c;
        int sym;
        int idx;
        accum = {accum[14:0], b};
        acc_have++;
        if (acc_have < acc_need)
            return;
        c = accum;
        case (phase)
            PH_SYM:
            begin
                if (c[4:3] == 2'd1 || c[4:3] == 2'd2)
                    acc_need = 8;
                else if (c[4:3] == 2'd0)
                    acc_need = (c[2:1] == 2'd3) ? 8 : 7;
                else
                    acc_need = (c[2:0] == 3'd0) ? 8 : 9;
                phase = PH_SYMX;
            end
            PH_SYMX:
            begin
                if (acc_need == 7)
                    sym = c + 256;
                else if (acc_need == 8)
                    sym = (c < 'hC0) ? int'(8'(c - 48)) : c + 88;
                else
                    sym = int'(8'(c - 256));
                if (sym < 256)
                begin
                    emit_byte(8'(sym));
                    open_field(PH_SYM, 5);
                end
                else if (sym == 256)
                    finish_block();
                else if (sym > 285)
                    abort_stream(ERR_LEN);
                else
                begin
                    idx = sym - 257;
                    run_len = LEN_BASE[idx];
                    if (LEN_EXTRA[idx] != 0)
                        open_field(PH_LENX, LEN_EXTRA[idx]);
                    else
                        open_field(PH_DIST, 5);
                end
            end
            PH_LENX:
            begin
                run_len = run_len + 9'(c);
                open_field(PH_DIST, 5);
            end
            PH_DIST:
            begin
                if (c >= 30)
                    abort_stream(ERR_DIST);
                else
                begin
                    run_dist = DIST_BASE[c];
                    if (DIST_EXTRA[c] != 0)
                        open_field(PH_DISTX, DIST_EXTRA[c]);
                    else
                    begin
                        copy_back();
                        open_field(PH_SYM, 5);
                    end
                end
            end
            default:
            begin
                run_dist = run_dist + c;
                copy_back();
                open_field(PH_SYM, 5);
            end
        endcase
    endtask

    // Works out every result word that one accepted compressed byte causes.
    task automatic predict_byte(input logic [7:0] b, input logic fin);
        int i;
        pend_n = 0;
        if (!done_flag)
        begin
            if (phase == PH_HEADER)
            begin
                last_blk = b[7];
                if (b[5])
                    open_field(PH_SYM, 5);
                else
                begin
                    phase = PH_STORED;
                    stored_left = DEF_STORED_BLOCK_LEN;
                    if (fin)
                        finish_block();
                end
            end
            else if (phase == PH_STORED)
            begin
                if (stored_left == 0)
                    finish_block();
                else if (fin && stored_left > 1)
                    finish_block();
                else
                begin
                    emit_byte(b);
                    stored_left--;
                    if (fin)
                        finish_block();
                end
            end
            else
            begin
                for (i = 7; i >= 0; i--)
                begin
                    if (done_flag || phase < PH_SYM)
                        break;
                    decode_bit(b[i]);
                end
            end
            if (fin && !done_flag)
                abort_stream(ERR_TRUNC);
        end
        close_word(1'b1);
    endtask

    // Directed symbols: literal extremes, shortest and longest copies, extra bits, far distances.
    sym_row_t directed_rows [] = '{
        '{ROW_LIT, 0, 0},
        '{ROW_LIT, 143, 0},
        '{ROW_LIT, 144, 0},
        '{ROW_LIT, 255, 0},
        '{ROW_COPY, 3, 1},
        '{ROW_COPY, 258, 4},
        '{ROW_COPY, 10, 2},
        '{ROW_COPY, 11, 5},
        '{ROW_COPY, 257, 200},
        '{ROW_COPY, 227, 512},
        '{ROW_LIT, 77, 0},
        '{ROW_EOB, 0, 0},
        '{ROW_LIT, 200, 0},
        '{ROW_COPY, 130, 700},
        '{ROW_COPY, 35, 1},
        '{ROW_EOB, 0, 0}
    };

    // Builds the whole compressed stream: directed rows, random blocks, then one ending.
    task automatic build_stream();
        stream_end_t ending;
        int r;
        int n;
        pack_bits = 0;
        built_len = 0;
        build_header(1'b0, 1'b1);
        foreach (directed_rows[k])
        begin
            case (directed_rows[k].kind)
                ROW_LIT:  build_literal(directed_rows[k].arg_a);
                ROW_COPY: build_copy(directed_rows[k].arg_a, directed_rows[k].arg_b);
                default:
                begin
                    build_eob();
                    build_header(1'b0, 1'b1);
                end
            endcase
        end
        while (comp_stream.size() < 320)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                build_literal($urandom_range(0, 255));
            else if (r < 92)
                build_random_copy();
            else
            begin
                build_eob();
                build_header(1'b0, 1'b1);
            end
        end
        ending = stream_end_t'($urandom_range(0, 6));
        case (ending)
            END_BAD_LEN:
            begin
                pack_bits_msb('hC6 + $urandom_range(0, 1), 8);
                pad_byte();
            end
            END_BAD_DIST:
            begin
                pack_bits_msb(1, 7);
                pack_bits_msb(30 + $urandom_range(0, 1), 5);
                pad_byte();
            end
            END_CUT_FIXED:
            begin
                build_literal($urandom_range(0, 255));
                pad_byte();
                comp_stream[$].fin = 1'b1;
            end
            END_LAST_FIXED:
            begin
                build_eob();
                build_header(1'b1, 1'b1);
                build_literal($urandom_range(0, 255));
                build_random_copy();
                build_eob();
            end
            default:
            begin
                build_eob();
                build_header(ending != END_STORED_OPEN, 1'b0);
                n = (ending == END_STORED_HDR_FINAL) ? 0 : $urandom_range(1, 12);
                repeat (n)
                    comp_stream.push_back('{8'($urandom), 1'b0});
                comp_stream[$].fin = 1'b1;
            end
        endcase
        // Three words after the end of the stream, which the unit answers with empty closing words.
        repeat (3)
            comp_stream.push_back('{8'($urandom), 1'($urandom)});
    endtask

    function automatic int pick_gap();
        if (lazy_side)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(5, 40);
        return $urandom_range(0, 2);
    endfunction

    // Reset, stimulus and end of run.
    initial
    begin
        in_word_t w;
        int gap;
        int waited;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_byte     = '0;
        in_final    = 1'b0;
        out_ready   = 1'b0;
        fail_count  = 0;
        words_checked = 0;
        bytes_sent  = 0;
        lazy_side   = 1'b0;
        hist_ptr    = '0;
        phase       = PH_HEADER;
        accum       = '0;
        acc_have    = 0;
        acc_need    = 0;
        run_len     = '0;
        run_dist    = '0;
        stored_left = 0;
        last_blk    = 1'b0;
        done_flag   = 1'b0;
        err_state   = ERR_NONE;
        pend_n      = 0;
        build_stream();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (comp_stream.size() > 0)
        begin
            w = comp_stream.pop_front();
            gap = pick_gap();
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_byte  <= w.data;
            in_final <= w.fin;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
        end
        in_valid <= 1'b0;
        waited = 0;
        while (decoded_due.size() > 0 && waited < IDLE_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (60) @(posedge clk);
        $display("Sent %0d compressed bytes, checked %0d result words; final error code %0d.",
                 bytes_sent, words_checked, err_state);
        if (fail_count == 0 && decoded_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Output stall pattern, with stretches where neither side idles.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 299) == 0)
            lazy_side <= ~lazy_side;
        if (lazy_side)
            out_ready <= 1'b1;
        else if ($urandom_range(0, 19) == 0)
            out_ready <= 1'b0;
        else if (!out_ready && $urandom_range(0, 3) != 0)
            out_ready <= 1'b0;
        else
            out_ready <= 1'b1;
    end

    // Checker, predictor trigger and watchdog.
    always @(posedge clk)
    begin
        out_word_t   exp_w;
        logic [7:0]  got [OUT_BYTES];
        bit          moved;
        if (rst_n)
        begin
            moved = (out_valid && out_ready) || (in_valid && in_ready);
            idle_cycles <= moved ? 0 : idle_cycles + 1;
            if (out_valid && out_ready)
            begin
                words_checked <= words_checked + 1;
                got = '{out_byte0, out_byte1, out_byte2, out_byte3,
                        out_byte4, out_byte5, out_byte6, out_byte7};
                if (decoded_due.size() == 0)
                begin
                    $display("%0t: unexpected word, count %0d", $time, out_count);
                    fail_count++;
                end
                else
                begin
                    exp_w = decoded_due.pop_front();
                    for (int j = 0; j < OUT_BYTES; j++)
                    begin
                        if (got[j] !== exp_w.bytes[j])
                        begin
                            $display("%0t: byte%0d expected %h got %h",
                                     $time, j, exp_w.bytes[j], got[j]);
                            fail_count++;
                        end
                    end
                    if (out_count !== exp_w.count)
                    begin
                        $display("%0t: count expected %0d got %0d", $time, exp_w.count, out_count);
                        fail_count++;
                    end
                    if (out_last !== exp_w.last)
                    begin
                        $display("%0t: last expected %b got %b", $time, exp_w.last, out_last);
                        fail_count++;
                    end
                    if (stream_done !== exp_w.done)
                    begin
                        $display("%0t: done expected %b got %b", $time, exp_w.done, stream_done);
                        fail_count++;
                    end
                    if (error_code !== exp_w.err)
                    begin
                        $display("%0t: error expected %0d got %0d", $time, exp_w.err, error_code);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                bytes_sent <= bytes_sent + 1;
                predict_byte(in_byte, in_final);
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
        else
            idle_cycles <= 0;
    end

endmodule
